@@ rtl/core/bat_pkg.sv @@
// Shared types and constants for the breakpoint address table.
package bat_pkg;

  localparam int unsigned BpEntries  = 16;
  localparam int unsigned BpTypeBits = 2;

  typedef enum logic [2:0] {
    CMD_SET         = 3'd0,
    CMD_DELETE      = 3'd1,
    CMD_DELETE_KIND = 3'd2,
    CMD_LOOKUP      = 3'd3,
    CMD_READ        = 3'd4
  } bp_cmd_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] address;
    logic [1:0]  bp_type;
    logic [3:0]  slot;
  } bp_req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] read_address;
  } bp_rsp_t;

  // Request token walking the cell chain, with the flags gathered so far.
  typedef struct packed {
    logic        active;
    logic [2:0]  cmd;
    logic [31:0] address;
    logic [3:0]  slot;
    logic        hit;
    logic        dup;
    logic        free_found;
    logic        rd_ok;
    logic [31:0] rd_addr;
  } bp_tok_t;

  // Broadcast from the chain end: commit a pending set, drop candidate marks.
  typedef struct packed {
    logic        commit;
    logic        clear;
    logic [31:0] address;
  } bp_wr_t;

endpackage

@@ rtl/core/bat_cell.sv @@
// One table entry: holds valid, kind and address, and passes the request token on.
module bat_cell import bat_pkg::*; #(
  parameter int unsigned Idx      = 0,
  parameter int unsigned TypeBits = BpTypeBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  bp_tok_t             tok_i,
  input  logic [TypeBits-1:0] kind_i,
  input  bp_wr_t              wr_i,
  input  logic [TypeBits-1:0] wr_kind_i,
  output bp_tok_t             tok_o,
  output logic [TypeBits-1:0] kind_o
);

  localparam bit Fixed = (Idx == 0);

  logic                valid_q, valid_d;
  logic [TypeBits-1:0] kind_q, kind_d;
  logic [31:0]         addr_q, addr_d;
  logic                cand_q, cand_d;
  bp_tok_t             tok_q, tok_d;
  logic [TypeBits-1:0] tkind_q;

  logic addr_eq, kind_eq, slot_eq;

  assign addr_eq = valid_q && (addr_q == tok_i.address);
  assign kind_eq = (kind_q == kind_i);
  assign slot_eq = (32'(tok_i.slot) == Idx);

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    kind_d  = kind_q;
    addr_d  = addr_q;
    cand_d  = cand_q;
    if (tok_i.active) begin
      case (tok_i.cmd)
        CMD_SET: begin
          if (addr_eq && kind_eq) tok_d.dup = 1'b1;
          // lowest free entry marks itself as the place for the new breakpoint
          if (!tok_i.free_found && !valid_q) begin
            tok_d.free_found = 1'b1;
            cand_d           = 1'b1;
          end
        end
        CMD_DELETE: begin
          if (slot_eq && !Fixed) valid_d = 1'b0;
        end
        CMD_DELETE_KIND: begin
          if (kind_eq && !Fixed) valid_d = 1'b0;
        end
        CMD_LOOKUP: begin
          if (addr_eq) tok_d.hit = 1'b1;
        end
        CMD_READ: begin
          if (slot_eq && valid_q) begin
            tok_d.rd_ok   = 1'b1;
            tok_d.rd_addr = addr_q;
          end
        end
        default: begin
        end
      endcase
    end
    if (wr_i.commit && cand_q) begin
      valid_d = 1'b1;
      kind_d  = wr_kind_i;
      addr_d  = wr_i.address;
    end
    if (wr_i.clear) cand_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= Fixed;
      kind_q  <= '0;
      addr_q  <= '0;
      cand_q  <= 1'b0;
      tok_q   <= '0;
      tkind_q <= '0;
    end else if (adv_i) begin
      valid_q <= valid_d;
      kind_q  <= kind_d;
      addr_q  <= addr_d;
      cand_q  <= cand_d;
      tok_q   <= tok_d;
      tkind_q <= kind_i;
    end
  end

  assign tok_o  = tok_q;
  assign kind_o = tkind_q;

endmodule

@@ rtl/core/breakpoint_address_table.sv @@
// Breakpoint address table: a chain of entry cells walked by each request.
// The token is registered at the head, in each cell in turn and, as a result, in
// the output register; a new request waits until the last has left the chain end.
// It visits one cell per cycle unless a stalled output holds the chain; a set is
// committed when it leaves the end. Reset: entry 0 valid, kind 0, address 0;
// all other entries free, no clearing pass, requests taken once reset is released.
module breakpoint_address_table import bat_pkg::*; #(
  parameter int unsigned Entries  = BpEntries,
  parameter int unsigned TypeBits = BpTypeBits
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  bp_req_t in_req_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output bp_rsp_t out_rsp_o
);

  bp_tok_t             tok   [Entries+1];
  logic [TypeBits-1:0] tkind [Entries+1];

  bp_tok_t             head_q;
  logic [TypeBits-1:0] head_kind_q;
  logic                busy_q;
  logic                out_valid_q;
  bp_rsp_t             out_rsp_q;

  logic    accept, adv, fire;
  bp_tok_t tail;
  bp_wr_t  wr;
  bp_rsp_t rsp_d;

  assign accept = in_valid_i && !busy_q;
  assign tail   = tok[Entries];
  // whole chain holds while a finished request waits on a full output register
  assign adv    = !(tail.active && out_valid_q && out_stall_i);
  assign fire   = tail.active && adv;

  assign tok[0]   = head_q;
  assign tkind[0] = head_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      head_kind_q <= '0;
    end else if (accept) begin
      head_q.active     <= 1'b1;
      head_q.cmd        <= in_req_i.command;
      head_q.address    <= in_req_i.address;
      head_q.slot       <= in_req_i.slot;
      head_q.hit        <= 1'b0;
      head_q.dup        <= 1'b0;
      head_q.free_found <= 1'b0;
      head_q.rd_ok      <= 1'b0;
      head_q.rd_addr    <= '0;
      head_kind_q       <= TypeBits'(in_req_i.bp_type);
    end else if (adv) begin
      head_q.active <= 1'b0;
    end
  end

  always_comb begin
    wr.commit  = fire && (tail.cmd == CMD_SET) && !tail.dup && tail.free_found;
    wr.clear   = fire;
    wr.address = tail.address;
  end

  for (genvar i = 0; i < Entries; i++) begin : g_cell
    bat_cell #(
      .Idx      (i),
      .TypeBits (TypeBits)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .tok_i     (tok[i]),
      .kind_i    (tkind[i]),
      .wr_i      (wr),
      .wr_kind_i (tkind[Entries]),
      .tok_o     (tok[i+1]),
      .kind_o    (tkind[i+1])
    );
  end

  always_comb begin
    rsp_d = '0;
    case (tail.cmd)
      CMD_SET:         rsp_d.ok = tail.dup || tail.free_found;
      CMD_DELETE:      rsp_d.ok = (tail.slot != '0) && (32'(tail.slot) < Entries);
      CMD_DELETE_KIND: rsp_d.ok = 1'b1;
      CMD_LOOKUP:      rsp_d.ok = tail.hit;
      CMD_READ: begin
        rsp_d.ok = tail.rd_ok;
        if (tail.rd_ok) rsp_d.read_address = tail.rd_addr;
      end
      default:         rsp_d.ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (fire) begin
        busy_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        out_rsp_q   <= rsp_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

@@ rtl/core/bat_chk.sv @@
// Port-level checks for the breakpoint address table, bound to the top level.
module bat_chk import bat_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_stall_o,
  input logic    out_valid_o,
  input logic    out_stall_i,
  input bp_rsp_t out_rsp_o
);

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another is in flight");

  // the head and cell registers keep a result from appearing right after acceptance
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after acceptance");

  a_read_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.ok |-> out_rsp_o.read_address == 32'd0)
    else $error("read address non-zero on a failed request");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result dropped or changed");

endmodule

bind breakpoint_address_table bat_chk u_bat_chk (.*);
